[design/ucs_to_utf8_encoder_core_macros.svh]
// ----------------------------------------------------------------------------
// ucs_to_utf8_encoder_core_macros.svh
// assertion macros for the utf-8 encoder serializer
// ----------------------------------------------------------------------------
`ifndef UCS_TO_UTF8_ENCODER_CORE_MACROS_SVH
`define UCS_TO_UTF8_ENCODER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define U8ENC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define U8ENC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/u8enc_pkg.sv]
// ----------------------------------------------------------------------------
// u8enc_pkg
// shared types and constants for the utf-8 encoder
// ----------------------------------------------------------------------------
package u8enc_pkg;

    localparam int SEQ_MAX = 6;
    localparam int CNT_W   = 3;

    // lead byte prefixes by sequence length
    localparam logic [7:0] LEAD_2 = 8'hC0;
    localparam logic [7:0] LEAD_3 = 8'hE0;
    localparam logic [7:0] LEAD_4 = 8'hF0;
    localparam logic [7:0] LEAD_5 = 8'hF8;
    localparam logic [7:0] LEAD_6 = 8'hFC;
    localparam logic [7:0] CONT_PREFIX = 8'h80;

    // sequence lengths
    localparam logic [CNT_W-1:0] LEN_1 = 3'd1;
    localparam logic [CNT_W-1:0] LEN_2 = 3'd2;
    localparam logic [CNT_W-1:0] LEN_3 = 3'd3;
    localparam logic [CNT_W-1:0] LEN_4 = 3'd4;
    localparam logic [CNT_W-1:0] LEN_5 = 3'd5;
    localparam logic [CNT_W-1:0] LEN_6 = 3'd6;

    // length thresholds
    localparam logic [31:0] LIM_1 = 32'h0000_0080;
    localparam logic [31:0] LIM_2 = 32'h0000_0800;
    localparam logic [31:0] LIM_3 = 32'h0001_0000;
    localparam logic [31:0] LIM_4 = 32'h0020_0000;
    localparam logic [31:0] LIM_5 = 32'h0400_0000;

    // config register map
    localparam logic REG_WIDE_MODE = 1'b0;
    localparam logic WIDE_MODE_RST = 1'b1;

    // one encoded sequence, lead byte in slot 0
    typedef struct packed {
        logic [SEQ_MAX-1:0][7:0] bytes;
        logic [CNT_W-1:0]        count;
        logic                    bad;
    } enc_seq_t;

endpackage

[design/ucs_to_utf8_encoder_core.sv]
// ----------------------------------------------------------------------------
// ucs_to_utf8_encoder_core
// utf-8 encoder: one code point in, one to six encoded bytes out
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                               handshake
//  s_*       in   tdata[31:0] code_point                tvalid/tready
//  m_*       out  tdata[7:0] utf8_byte, tlast last_byte  tvalid/tready
//                 tuser[0] bad_code
//  apb       in   wide_mode at byte address 0           psel/penable
//
//  a code point taking n bytes (1 to 6) occupies the output until its last byte is sent;
//  the byte-wide result channel sets the rate, one byte per cycle while m_tready is high
//  the path runs through the input register, then the result register
//  reset clears both valid flags and sets wide_mode to 1
//  a stall on m_* backs up into the input register, then drops s_tready
//
module ucs_to_utf8_encoder_core
(
    input  logic        clk,
    input  logic        rst_n,

    // input code points
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [31:0] code_point

    // encoded bytes
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [7:0] utf8_byte
    output logic        m_tlast,     // last_byte
    output logic        m_tuser,     // [0] bad_code

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                wide_mode_reg;
    logic                in_valid_reg;
    logic [31:0]         code_reg;
    logic                load_ready;
    logic                cfg_write;
    u8enc_pkg::enc_seq_t seq;

    // ---------------------------------------------------------------- apb
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_mode_reg <= u8enc_pkg::WIDE_MODE_RST;
        end
        else if (cfg_write && paddr[2] == u8enc_pkg::REG_WIDE_MODE)
        begin
            wide_mode_reg <= pwdata[0];
        end
    end

    // only one register; the low address bits are ignored
    assign prdata = (paddr[2] == u8enc_pkg::REG_WIDE_MODE) ? {31'h0, wide_mode_reg} : 32'h0;

    // ------------------------------------------------------ input register
    // refills in the same cycle it hands its code point on
    assign s_tready = !in_valid_reg || load_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            code_reg <= s_tdata;
        end
    end

    // ------------------------------------------------------------- encode
    u8enc_encode u_encode
    (
        .wide_mode  (wide_mode_reg),
        .code_point (code_reg),
        .seq        (seq)
    );

    // ---------------------------------------------------------- serialize
    u8enc_serializer u_serializer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (in_valid_reg),
        .load_ready (load_ready),
        .seq        (seq),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

[design/u8enc_encode.sv]
// ----------------------------------------------------------------------------
// u8enc_encode
// combinational code point to utf-8 byte sequence
// ----------------------------------------------------------------------------
module u8enc_encode
(
    input  logic                 wide_mode,
    input  logic [31:0]          code_point,
    output u8enc_pkg::enc_seq_t  seq
);

    logic [31:0]                 v;
    logic [u8enc_pkg::CNT_W-1:0] n;
    logic [4:0][7:0]             cont;

    assign v = wide_mode ? code_point : {16'h0000, code_point[15:0]};

    always_comb
    begin
        if (v < u8enc_pkg::LIM_1)      n = u8enc_pkg::LEN_1;
        else if (v < u8enc_pkg::LIM_2) n = u8enc_pkg::LEN_2;
        else if (v < u8enc_pkg::LIM_3) n = u8enc_pkg::LEN_3;
        else if (v < u8enc_pkg::LIM_4) n = u8enc_pkg::LEN_4;
        else if (v < u8enc_pkg::LIM_5) n = u8enc_pkg::LEN_5;
        else                           n = u8enc_pkg::LEN_6;
    end

    // continuation bytes, index 0 carries the lowest six bits
    always_comb
    begin
        for (int j = 0; j < 5; j++)
        begin
            cont[j] = u8enc_pkg::CONT_PREFIX | {2'b00, v[6*j +: 6]};
        end
    end

    always_comb
    begin
        seq       = '0;
        seq.count = n;
        seq.bad   = 1'b0;
        unique case (n)
            u8enc_pkg::LEN_1:
            begin
                seq.bytes[0] = {1'b0, v[6:0]};
            end
            u8enc_pkg::LEN_2:
            begin
                seq.bytes[0] = u8enc_pkg::LEAD_2 | {3'b000, v[10:6]};
                seq.bytes[1] = cont[0];
            end
            u8enc_pkg::LEN_3:
            begin
                seq.bytes[0] = u8enc_pkg::LEAD_3 | {4'h0, v[15:12]};
                seq.bytes[1] = cont[1];
                seq.bytes[2] = cont[0];
            end
            u8enc_pkg::LEN_4:
            begin
                seq.bytes[0] = u8enc_pkg::LEAD_4 | {5'h00, v[20:18]};
                seq.bytes[1] = cont[2];
                seq.bytes[2] = cont[1];
                seq.bytes[3] = cont[0];
            end
            u8enc_pkg::LEN_5:
            begin
                seq.bytes[0] = u8enc_pkg::LEAD_5 | {6'h00, v[25:24]};
                seq.bytes[1] = cont[3];
                seq.bytes[2] = cont[2];
                seq.bytes[3] = cont[1];
                seq.bytes[4] = cont[0];
            end
            default:
            begin
                seq.bytes[0] = u8enc_pkg::LEAD_6 | {7'h00, v[30]};
                seq.bytes[1] = cont[4];
                seq.bytes[2] = cont[3];
                seq.bytes[3] = cont[2];
                seq.bytes[4] = cont[1];
                seq.bytes[5] = cont[0];
            end
        endcase

        // out of range in wide mode: single zero byte flagged bad
        if (wide_mode && code_point[31])
        begin
            seq       = '0;
            seq.count = u8enc_pkg::LEN_1;
            seq.bad   = 1'b1;
        end
    end

endmodule

[design/u8enc_serializer.sv]
// ----------------------------------------------------------------------------
// u8enc_serializer
// result register that shifts one encoded byte out per request
// ----------------------------------------------------------------------------
`include "ucs_to_utf8_encoder_core_macros.svh"

module u8enc_serializer
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load_valid,
    output logic                load_ready,
    input  u8enc_pkg::enc_seq_t seq,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast,
    output logic                m_tuser
);

    logic                                       valid_reg;
    logic [u8enc_pkg::CNT_W-1:0]                left_reg;
    logic [u8enc_pkg::SEQ_MAX-1:0][7:0]         bytes_reg;
    logic                                       bad_reg;
    logic                                       last;
    logic                                       load;
    logic                                       take;

    assign last       = (left_reg == u8enc_pkg::LEN_1);
    assign take       = valid_reg && m_tready;
    assign load_ready = !valid_reg || (m_tready && last);
    assign load       = load_valid && load_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            left_reg  <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            left_reg  <= seq.count;
        end
        else if (take)
        begin
            valid_reg <= !last;
            left_reg  <= left_reg - u8enc_pkg::LEN_1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= seq.bytes;
            bad_reg   <= seq.bad;
        end
        else if (take)
        begin
            bytes_reg <= {8'h00, bytes_reg[u8enc_pkg::SEQ_MAX-1:1]};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = bytes_reg[0];
    assign m_tlast  = last;
    assign m_tuser  = bad_reg;

    `U8ENC_ASSERT_NOW(a_count_live, valid_reg, left_reg != '0 && left_reg <= u8enc_pkg::LEN_6, "serializer holds a sequence with no bytes left")
    `U8ENC_ASSERT_NOW(a_bad_single, valid_reg && bad_reg, last && bytes_reg[0] == 8'h00, "bad code result is not a single zero byte")
    `U8ENC_ASSERT_NEXT(a_mid_seq, take && !last, valid_reg, "sequence dropped before its last byte")

endmodule
